// File: rtl/core/iee_pkg.sv
package iee_pkg;

  // Operator codes held on the operator stack.
  localparam logic [2:0] OPC_LPAR  = 3'd0;
  localparam logic [2:0] OPC_ADD   = 3'd1;
  localparam logic [2:0] OPC_SUB   = 3'd2;
  localparam logic [2:0] OPC_MUL   = 3'd3;
  localparam logic [2:0] OPC_DIV   = 3'd4;
  localparam logic [2:0] OPC_POW   = 3'd5;
  localparam logic [2:0] OPC_OTHER = 3'd6;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_POW  = 8'h5E;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_LPAR = 8'h28;
  localparam logic [7:0] CH_RPAR = 8'h29;
  localparam logic [7:0] CH_D0   = 8'h30;
  localparam logic [7:0] CH_D9   = 8'h39;

  // Request to the arithmetic unit and its answer.
  typedef struct packed {
    logic        start;
    logic [2:0]  opc;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic        div0;
    logic [31:0] res;
  } alu_rsp_t;

  function automatic logic [1:0] prec(input logic [2:0] opc);
    case (opc)
      OPC_POW:          prec = 2'd3;
      OPC_MUL, OPC_DIV: prec = 2'd2;
      OPC_ADD, OPC_SUB: prec = 2'd1;
      default:          prec = 2'd0;
    endcase
  endfunction

  function automatic logic [2:0] classify(input logic [7:0] c);
    case (c)
      CH_POW:  classify = OPC_POW;
      CH_MUL:  classify = OPC_MUL;
      CH_DIV:  classify = OPC_DIV;
      CH_ADD:  classify = OPC_ADD;
      CH_SUB:  classify = OPC_SUB;
      default: classify = OPC_OTHER;
    endcase
  endfunction

endpackage

// File: rtl/core/iee_alu.sv
module iee_alu
  import iee_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_DIV  = 3'd1;
  localparam logic [2:0] A_POW  = 3'd2;
  localparam logic [2:0] A_PSQ  = 3'd3;
  localparam logic [2:0] A_DONE = 3'd4;

  logic [2:0]  st_r, st_nxt;
  logic [31:0] x_r, x_nxt;     // dividend shift / power base
  logic [31:0] y_r, y_nxt;     // divisor magnitude / exponent
  logic [31:0] acc_r, acc_nxt; // quotient / power result
  logic [32:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic        div0_r, div0_nxt;
  logic [31:0] prod;
  logic [31:0] mula, mulb;
  logic [32:0] trial;
  logic [31:0] ma, mb;

  // One shared 32x32 multiplier, low word only.
  assign prod = mula * mulb;
  always_comb begin
    mula = acc_r;
    mulb = x_r;
    if (st_r == A_PSQ) begin
      mula = x_r;
    end else if (st_r == A_IDLE) begin
      mula = req.a;
      mulb = req.b;
    end
  end

  assign ma    = req.a[31] ? 32'd0 - req.a : req.a;
  assign mb    = req.b[31] ? 32'd0 - req.b : req.b;
  assign trial = {rem_r[31:0], x_r[31]} - {1'b0, y_r};

  always_comb begin
    st_nxt = st_r; x_nxt = x_r; y_nxt = y_r; acc_nxt = acc_r;
    rem_nxt = rem_r; cnt_nxt = cnt_r; neg_nxt = neg_r; div0_nxt = div0_r;
    case (st_r)
      A_IDLE: begin
        if (req.start) begin
          div0_nxt = 1'b0;
          st_nxt   = A_DONE;
          case (req.opc)
            OPC_ADD: acc_nxt = req.a + req.b;
            OPC_MUL: acc_nxt = prod;
            OPC_DIV: begin
              if (req.b == 32'd0) begin
                acc_nxt = 32'd0; div0_nxt = 1'b1;
              end else begin
                x_nxt = ma; y_nxt = mb; rem_nxt = '0; acc_nxt = '0;
                cnt_nxt = 5'd31; neg_nxt = req.a[31] ^ req.b[31];
                st_nxt = A_DIV;
              end
            end
            OPC_POW: begin
              if (req.b[31]) begin
                if (req.a == 32'd1) acc_nxt = 32'd1;
                else if (req.a == 32'hFFFF_FFFF)
                  acc_nxt = req.b[0] ? 32'hFFFF_FFFF : 32'd1;
                else begin
                  acc_nxt = 32'd0; div0_nxt = (req.a == 32'd0);
                end
              end else begin
                x_nxt = req.a; y_nxt = req.b; acc_nxt = 32'd1;
                st_nxt = A_POW;
              end
            end
            default: acc_nxt = req.a - req.b;
          endcase
        end
      end
      // Restoring division, one quotient bit per cycle.
      A_DIV: begin
        if (!trial[32]) begin
          rem_nxt = trial;
          acc_nxt = {acc_r[30:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[31:0], x_r[31]};
          acc_nxt = {acc_r[30:0], 1'b0};
        end
        x_nxt = {x_r[30:0], 1'b0};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          if (neg_r) acc_nxt = 32'd0 - acc_nxt;
          st_nxt = A_DONE;
        end
      end
      // Square and multiply: multiply step, then squaring step.
      A_POW: begin
        if (y_r == 32'd0) st_nxt = A_DONE;
        else begin
          if (y_r[0]) acc_nxt = prod;
          st_nxt = A_PSQ;
        end
      end
      A_PSQ: begin
        x_nxt = prod;
        y_nxt = {1'b0, y_r[31:1]};
        st_nxt = A_POW;
      end
      A_DONE: st_nxt = A_IDLE;
      default: st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; acc_r <= acc_nxt; rem_r <= rem_nxt;
    cnt_r <= cnt_nxt; neg_r <= neg_nxt; div0_r <= div0_nxt;
  end

  assign rsp.done = (st_r == A_DONE);
  assign rsp.div0 = div0_r;
  assign rsp.res  = acc_r;

endmodule

// File: rtl/core/infix_expression_evaluator.sv
// Sequence: a beat is accepted in S_IDLE, dispatched in S_DISP and closed in S_FIN.
// Each reduction passes S_RED, S_RED2, S_WAIT and S_PUSHR; the arithmetic unit ends at once
// for add, subtract, multiply, division by zero and a negative exponent, and iterates for
// division and power. The last character adds the drain and a result beat held until taken.
// Throughput: one character at a time; the sequencer and the shared arithmetic
// unit set the rate. Synchronous active-low reset empties both stacks and the error.
module infix_expression_evaluator
  import iee_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] value, [33:32] status, rest zero
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_RED   = 4'd2;
  localparam logic [3:0] S_RED2  = 4'd3;
  localparam logic [3:0] S_WAIT  = 4'd4;
  localparam logic [3:0] S_PUSHR = 4'd5;
  localparam logic [3:0] S_FIN   = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  logic [3:0]    st_r, st_nxt;
  logic [7:0]    ch_r;
  logic          last_r;
  logic          drain_r, drain_nxt;
  logic [CW-1:0] ocnt_r, ocnt_nxt, pcnt_r, pcnt_nxt;
  logic [1:0]    err_r, err_nxt;
  logic [31:0]   opnd_mem [STACK_DEPTH];
  logic [2:0]    opr_mem [STACK_DEPTH];
  logic [31:0]   b_r, b_nxt;
  logic [2:0]    opc_r, opc_nxt;
  logic [31:0]   value_r;
  logic [1:0]    status_r;
  logic          we_d, we_p;
  logic [AW-1:0] wa_d, wa_p;
  logic [31:0]   wd_d;
  logic [2:0]    wd_p;
  logic [31:0]   rd_d;
  logic [2:0]    rd_p;
  logic [AW-1:0] ra_d, ra_p;
  logic [2:0]    cur_opc;
  logic          is_digit;
  alu_req_t      req;
  alu_rsp_t      rsp;

  iee_alu u_alu (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  // Stacks: one write and one registered read each; an operand written to the
  // address being read is passed straight to the read register.
  always_ff @(posedge clk) begin
    if (we_d) opnd_mem[wa_d] <= wd_d;
    if (we_p) opr_mem[wa_p] <= wd_p;
    if (we_d && wa_d == ra_d) rd_d <= wd_d;
    else rd_d <= opnd_mem[ra_d];
    rd_p <= opr_mem[ra_p];
  end

  assign is_digit = (ch_r >= CH_D0) && (ch_r <= CH_D9);
  assign cur_opc  = classify(ch_r);

  // Read addresses always track the top entries for the next cycle.
  always_comb begin
    ra_p = AW'(pcnt_nxt - CW'(1));
    ra_d = AW'(ocnt_nxt - CW'(1));
    if (st_nxt == S_RED2) ra_d = AW'(ocnt_nxt - CW'(2));
  end

  always_comb begin
    st_nxt = st_r; drain_nxt = drain_r; ocnt_nxt = ocnt_r; pcnt_nxt = pcnt_r;
    err_nxt = err_r; b_nxt = b_r; opc_nxt = opc_r;
    we_d = 1'b0; wa_d = AW'(ocnt_r); wd_d = rsp.res;
    we_p = 1'b0; wa_p = AW'(pcnt_r); wd_p = cur_opc;
    req = '0;
    req.opc = opc_r; req.a = rd_d; req.b = b_r;
    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          drain_nxt = 1'b0;
          st_nxt = S_DISP;
        end
      end
      // rd_p holds the top operator here.
      S_DISP: begin
        if (!drain_r && is_digit) begin
          if (ocnt_r == DEPTH_C) begin
            if (err_r == ST_OK) err_nxt = ST_BAD;
          end else begin
            we_d = 1'b1; wd_d = {24'd0, ch_r - CH_D0}; ocnt_nxt = ocnt_r + CW'(1);
          end
          st_nxt = S_FIN;
        end else if (!drain_r && ch_r == CH_LPAR) begin
          if (pcnt_r == DEPTH_C) begin
            if (err_r == ST_OK) err_nxt = ST_BAD;
          end else begin
            we_p = 1'b1; wd_p = OPC_LPAR; pcnt_nxt = pcnt_r + CW'(1);
          end
          st_nxt = S_FIN;
        end else if (pcnt_r == '0) begin
          if (drain_r) st_nxt = S_OUT;
          else if (ch_r == CH_RPAR) begin
            if (err_r == ST_OK) err_nxt = ST_BAD;
            st_nxt = S_FIN;
          end else begin
            we_p = 1'b1; pcnt_nxt = pcnt_r + CW'(1);
            st_nxt = S_FIN;
          end
        end else if (rd_p == OPC_LPAR) begin
          if (drain_r) begin
            pcnt_nxt = pcnt_r - CW'(1);
            if (err_r == ST_OK) err_nxt = ST_BAD;
          end else if (ch_r == CH_RPAR) begin
            pcnt_nxt = pcnt_r - CW'(1);
            st_nxt = S_FIN;
          end else begin
            if (pcnt_r == DEPTH_C) begin
              if (err_r == ST_OK) err_nxt = ST_BAD;
            end else begin
              we_p = 1'b1; pcnt_nxt = pcnt_r + CW'(1);
            end
            st_nxt = S_FIN;
          end
        end else if (drain_r || ch_r == CH_RPAR || prec(rd_p) >= prec(cur_opc)) begin
          // Pop the operator and start a reduction, or flag a malformed expression if fewer than two operands remain.
          opc_nxt = rd_p;
          pcnt_nxt = pcnt_r - CW'(1);
          if (ocnt_r < CW'(2)) begin
            if (err_r == ST_OK) err_nxt = ST_BAD;
          end else begin
            st_nxt = S_RED;
          end
        end else begin
          if (pcnt_r == DEPTH_C) begin
            if (err_r == ST_OK) err_nxt = ST_BAD;
          end else begin
            we_p = 1'b1; pcnt_nxt = pcnt_r + CW'(1);
          end
          st_nxt = S_FIN;
        end
      end
      // rd_d holds operand b; next read gives a.
      S_RED: begin
        b_nxt = rd_d;
        st_nxt = S_RED2;
      end
      S_RED2: begin
        req.start = 1'b1;
        ocnt_nxt = ocnt_r - CW'(2);
        st_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (rsp.done) begin
          if (rsp.div0 && err_r == ST_OK) err_nxt = ST_DIV0;
          st_nxt = S_PUSHR;
        end
      end
      S_PUSHR: begin
        we_d = 1'b1; wd_d = rsp.res; ocnt_nxt = ocnt_r + CW'(1);
        st_nxt = S_DISP;
      end
      S_FIN: begin
        if (last_r) begin
          drain_nxt = 1'b1;
          st_nxt = S_DISP;
        end else st_nxt = S_IDLE;
      end
      S_OUT: begin
        if (out_tready) begin
          ocnt_nxt = '0; pcnt_nxt = '0; err_nxt = ST_OK;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Result-beat payload: taken when the drain finds the operator stack empty.
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_tvalid) begin
      ch_r <= in_tdata; last_r <= in_tlast;
    end
    if (st_r != S_OUT) begin
      status_r <= (err_r != ST_OK) ? err_r : ((ocnt_r != CW'(1)) ? ST_BAD : ST_OK);
    end
    if (st_r == S_RED) value_r <= 32'd0;
    if (st_r == S_DISP && st_nxt == S_OUT) value_r <= rd_d;
    b_r <= b_nxt; opc_r <= opc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; drain_r <= 1'b0;
      ocnt_r <= '0; pcnt_r <= '0; err_r <= ST_OK;
    end else begin
      st_r <= st_nxt; drain_r <= drain_nxt;
      ocnt_r <= ocnt_nxt; pcnt_r <= pcnt_nxt; err_r <= err_nxt;
    end
  end

  // Operand 0 sits at the top when exactly one remains.
  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = {6'd0, status_r, (status_r == ST_OK) ? value_r : 32'd0};

endmodule

// File: verif/infix_expression_evaluator_checker.sv
module infix_expression_evaluator_checker
  import iee_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
  } answer_t;

  // Predictor state: a private copy of both stacks and the sticky error.
  logic [31:0] num_stack [STACK_DEPTH];
  logic [2:0]  op_stack [STACK_DEPTH];
  int          num_cnt;
  int          op_cnt;
  logic [1:0]  err;
  answer_t     answers [$];

  task automatic raise(input logic [1:0] code);
    if (err == ST_OK) err = code;
  endtask

  function automatic logic [1:0] rank(input logic [2:0] opc);
    case (opc)
      OPC_POW:          return 2'd3;
      OPC_MUL, OPC_DIV: return 2'd2;
      OPC_ADD, OPC_SUB: return 2'd1;
      default:          return 2'd0;
    endcase
  endfunction

  function automatic logic [2:0] opcode_of(input logic [7:0] c);
    case (c)
      CH_POW:  return OPC_POW;
      CH_MUL:  return OPC_MUL;
      CH_DIV:  return OPC_DIV;
      CH_ADD:  return OPC_ADD;
      CH_SUB:  return OPC_SUB;
      default: return OPC_OTHER;
    endcase
  endfunction

  task automatic push_num(input logic [31:0] v);
    if (num_cnt >= STACK_DEPTH) raise(ST_BAD);
    else begin
      num_stack[num_cnt] = v;
      num_cnt++;
    end
  endtask

  task automatic push_op(input logic [2:0] opc);
    if (op_cnt >= STACK_DEPTH) raise(ST_BAD);
    else begin
      op_stack[op_cnt] = opc;
      op_cnt++;
    end
  endtask

  task automatic compute(input logic [31:0] a, input logic [31:0] b,
                         input logic [2:0] opc, output logic [31:0] r);
    logic [31:0] ma, mb, q, base, ex;
    case (opc)
      OPC_ADD: r = a + b;
      OPC_MUL: r = a * b;
      OPC_DIV: begin
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        if (b == 0) begin
          raise(ST_DIV0);
          r = 0;
        end else begin
          q = ma / mb;
          r = (a[31] != b[31]) ? -q : q;
        end
      end
      OPC_POW: begin
        if (b[31]) begin
          if (a == 32'd1) r = 1;
          else if (a == '1) r = b[0] ? '1 : 32'd1;
          else begin
            if (a == 0) raise(ST_DIV0);
            r = 0;
          end
        end else begin
          // Square-and-multiply, wrapping at 32 bits.
          r = 1;
          base = a;
          ex = b;
          while (ex != 0) begin
            if (ex[0]) r = r * base;
            base = base * base;
            ex = ex >> 1;
          end
        end
      end
      default: r = a - b;
    endcase
  endtask

  task automatic reduce_top();
    logic [2:0]  opc;
    logic [31:0] r;
    opc = op_stack[op_cnt-1];
    op_cnt--;
    if (num_cnt < 2) raise(ST_BAD);
    else begin
      compute(num_stack[num_cnt-2], num_stack[num_cnt-1], opc, r);
      num_cnt -= 2;
      push_num(r);
    end
  endtask

  task automatic evaluate_char(input logic [7:0] c, input logic last);
    logic [2:0] opc;
    answer_t    ans;
    if (c >= CH_D0 && c <= CH_D9) push_num(32'(c - CH_D0));
    else if (c == CH_LPAR) push_op(OPC_LPAR);
    else if (c == CH_RPAR) begin
      while (op_cnt > 0 && op_stack[op_cnt-1] != OPC_LPAR) reduce_top();
      if (op_cnt == 0) raise(ST_BAD);
      else op_cnt--;
    end else begin
      opc = opcode_of(c);
      while (op_cnt > 0 && op_stack[op_cnt-1] != OPC_LPAR &&
             rank(op_stack[op_cnt-1]) >= rank(opc))
        reduce_top();
      push_op(opc);
    end
    if (last) begin
      // Drain; a leftover open parenthesis is a malformed expression.
      while (op_cnt > 0) begin
        if (op_stack[op_cnt-1] == OPC_LPAR) begin
          op_cnt--;
          raise(ST_BAD);
        end else reduce_top();
      end
      if (num_cnt != 1) raise(ST_BAD);
      ans.status = err;
      ans.value = (err == ST_OK) ? num_stack[0] : 32'd0;
      answers.push_back(ans);
      num_cnt = 0;
      op_cnt = 0;
      err = ST_OK;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // Predict on every input beat and compare every result beat.
  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      num_cnt = 0;
      op_cnt = 0;
      err = ST_OK;
      answers.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (answers.size() == 0) report_mismatch("result beat with none expected");
        else begin
          want = answers.pop_front();
          if (out_tdata[31:0] !== want.value)
            report_mismatch($sformatf("value %h, expected %h", out_tdata[31:0], want.value));
          if (out_tdata[33:32] !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_tdata[33:32], want.status));
          if (out_tdata[39:34] !== '0)
            report_mismatch("padding bits of result not zero");
        end
      end
      if (in_tvalid && in_tready) evaluate_char(in_tdata, in_tlast);
    end
    pending = answers.size();
  end
endmodule

// File: verif/infix_expression_evaluator_test.sv
module infix_expression_evaluator_test;
  import iee_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;
  int          fail_count;
  int          pending;
  int          results_seen;
  int          chars_sent = 0;
  int          exprs_sent = 0;
  bit          hold_off = 0;
  bit          stim_done = 0;

  infix_expression_evaluator dut (.*);

  infix_expression_evaluator_checker chk (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Send one character, idling a random number of cycles first when gaps is set.
  task automatic send_char(input logic [7:0] c, input logic last, input bit gaps);
    int idle;
    idle = gaps && $urandom_range(0, 2) != 0 ? $urandom_range(0, 18) : 0;
    if (idle > 0) begin
      in_tvalid <= 0;
      repeat (idle) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= c;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
    if (last) exprs_sent++;
  endtask

  task automatic send_text(input string s, input bit gaps);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1, gaps);
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_D0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 5))
      0: return CH_ADD;
      1: return CH_SUB;
      2: return CH_MUL;
      3: return CH_DIV;
      4: return CH_POW;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Build a mostly well-formed expression with random nesting.
  function automatic string make_expr(int depth);
    string s;
    int terms;
    terms = $urandom_range(1, 4);
    s = "";
    for (int t = 0; t < terms; t++) begin
      if (t > 0) s = {s, string'(rand_op())};
      if (depth < 4 && $urandom_range(0, 3) == 0) s = {s, "(", make_expr(depth + 1), ")"};
      else s = {s, string'(rand_digit())};
    end
    return s;
  endfunction

  // Receiver: random stalls, and one long hold-off while the sender runs.
  initial begin
    int idle;
    while (1) begin
      @(posedge clk);
      if (hold_off) out_tready <= 0;
      else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 0;
        idle = $urandom_range(0, 18);
        repeat (idle) @(posedge clk);
        out_tready <= 1;
      end else out_tready <= 1;
    end
  end

  initial begin
    string s;
    logic [7:0] c;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed expressions: every operator, parentheses, and the special cases.
    send_text("7", 0);
    send_text("9+8*7-6/3", 0);
    send_text("2^3^2", 0);
    send_text("(1+2)*3", 0);
    send_text("8/0", 0);
    send_text("2^(0-1)", 0);
    send_text("0^(0-3)", 0);
    send_text("(0-1)^(0-3)", 0);
    send_text("1^(0-2)", 0);
    send_text("0^0", 0);
    send_text("9a5", 0);
    send_text("3)", 0);
    send_text("(4", 0);
    send_text("+", 0);
    send_text("12", 0);
    send_text("9^9^9", 0);
    send_text("((((((((((((((((((1", 0);
    send_text("11111111111111111", 0);
    send_char(8'hFF, 1, 0);
    send_char(8'h00, 1, 0);

    // Long receiver hold-off while the sender keeps offering expressions.
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      for (int k = 0; k < 12; k++) send_text(make_expr(0), 1);
    join

    // Random part: mostly well-formed, some noise and broken sequences.
    while (chars_sent < 1300) begin
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 6)) begin
            c = 8'($urandom_range(0, 255));
            send_char(c, $urandom_range(0, 7) == 0, 1);
          end
        end
        1: begin
          s = make_expr(0);
          if (s.len() > 1) s = s.substr(0, $urandom_range(0, s.len() - 2));
          send_text(s, 1);
        end
        default: send_text(make_expr(0), $urandom_range(0, 4) != 0);
      endcase
    end
    send_char(CH_D0, 1, 1);
    in_tvalid <= 0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d characters forming %0d expressions; checked %0d results.",
             chars_sent, exprs_sent, results_seen);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end
endmodule
